@@ hw/rtl/fcpu_pkg.sv @@
// Package: shared constants, opcodes and a helper function for the fly camera pose unit.
`timescale 1ns / 1ps
package fcpu_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  localparam logic signed [31:0] DEG89  = 32'sd5832704;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] DEG360 = 32'sd23592960;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

  function automatic logic signed [24:0] atan_deg(input logic [3:0] i);
    logic signed [24:0] r;
    begin
      case (i)
        4'd0:  r = 25'sd2949120;
        4'd1:  r = 25'sd1740967;
        4'd2:  r = 25'sd919879;
        4'd3:  r = 25'sd466945;
        4'd4:  r = 25'sd234379;
        4'd5:  r = 25'sd117265;
        4'd6:  r = 25'sd58666;
        4'd7:  r = 25'sd29335;
        4'd8:  r = 25'sd14668;
        4'd9:  r = 25'sd7334;
        4'd10: r = 25'sd3667;
        4'd11: r = 25'sd1833;
        4'd12: r = 25'sd917;
        4'd13: r = 25'sd458;
        4'd14: r = 25'sd229;
        default: r = 25'sd115;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/fcpu_cordic.sv @@
// Iterative CORDIC: sine and cosine in Q4.14 of an angle in Q16.16 degrees.
`timescale 1ns / 1ps
module fcpu_cordic
  import fcpu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [17:0] cos_q,
  output logic signed [17:0] sin_q
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic neg_r, neg_nxt;
  logic done_r, done_nxt;
  logic signed [17:0] cos_r, cos_nxt, sin_r, sin_nxt;

  // angle % 360 computed by repeated subtraction would be long; use reduce by
  // stepped subtraction of 360*2^k instead
  logic [4:0] red_r, red_nxt;
  logic signed [33:0] sx, sy, xn, yn;
  logic signed [33:0] rx, ry;
  logic signed [32:0] dk;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    cos_nxt = cos_r;
    sin_nxt = sin_r;
    red_nxt = red_r;
    sx = x_r >>> step_r;
    sy = y_r >>> step_r;
    xn = '0;
    yn = '0;
    rx = '0;
    ry = '0;
    dk = 33'(DEG360) <<< red_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          z_nxt = 33'(angle);
          red_nxt = 5'd7;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        // binary reduction toward [0,360): one conditional subtract/add per cycle
        if (red_r != 5'd31) begin
          if (z_r >= dk) z_nxt = z_r - dk;
          else if (z_r < 0) z_nxt = z_r + dk;
          if (red_r == 5'd0) red_nxt = 5'd31;
          else red_nxt = red_r - 5'd1;
        end else begin
          if (z_r < 0) z_nxt = z_r + 33'(DEG360);
          else begin
            if (z_r >= 33'(DEG180)) z_nxt = z_r - 33'(DEG360);
            else z_nxt = z_r;
            if (z_nxt > 33'(DEG90)) begin
              z_nxt = z_nxt - 33'(DEG180);
              neg_nxt = 1'b1;
            end else if (z_nxt < -33'(DEG90)) begin
              z_nxt = z_nxt + 33'(DEG180);
              neg_nxt = 1'b1;
            end else neg_nxt = 1'b0;
            x_nxt = CORDIC_GAIN;
            y_nxt = '0;
            step_nxt = '0;
            state_nxt = S_ITER;
          end
        end
      end
      S_ITER: begin
        if (z_r >= 0) begin
          xn = x_r - sy;
          yn = y_r + sx;
          z_nxt = z_r - 33'(atan_deg(step_r));
        end else begin
          xn = x_r + sy;
          yn = y_r - sx;
          z_nxt = z_r + 33'(atan_deg(step_r));
        end
        x_nxt = xn;
        y_nxt = yn;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(CORDIC_STEPS - 1)) state_nxt = S_OUT;
      end
      default: begin
        rx = neg_r ? -x_r : x_r;
        ry = neg_r ? -y_r : y_r;
        rx = (rx + 34'sd32768) >>> 16;
        ry = (ry + 34'sd32768) >>> 16;
        cos_nxt = rx[17:0];
        sin_nxt = ry[17:0];
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    step_r <= step_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    neg_r <= neg_nxt;
    red_r <= red_nxt;
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

@@ hw/rtl/fcpu_norm.sv @@
// Vector normalizer: prescale, sum of squares, bit-serial square root and division.
`timescale 1ns / 1ps
module fcpu_norm
  import fcpu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] vx,
  input  logic signed [63:0] vy,
  input  logic signed [63:0] vz,
  output logic               done,
  output logic               zero,
  output logic signed [15:0] ux,
  output logic signed [15:0] uy,
  output logic signed [15:0] uz
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic signed [63:0] v_r [3];
  logic signed [63:0] v_nxt [3];
  logic [63:0] ss_r, ss_nxt;
  logic [63:0] rem_r, rem_nxt, root_r, root_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [47:0] num_r, num_nxt;
  logic [32:0] dr_r, dr_nxt;
  logic [15:0] q_r, q_nxt;
  logic [15:0] u_r [3];
  logic [15:0] u_nxt [3];
  logic done_r, done_nxt, zero_r, zero_nxt;

  logic big;
  logic [31:0] m;
  logic [63:0] sqm, trial, bitv;
  logic [32:0] dsh;
  logic [15:0] qc;
  logic [63:0] vm;

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < 3; i++) begin
      v_nxt[i] = v_r[i];
      u_nxt[i] = u_r[i];
    end
    ss_nxt = ss_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    num_nxt = num_r;
    dr_nxt = dr_r;
    q_nxt = q_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    big = 1'b0;
    vm = '0;
    m = '0;
    sqm = '0;
    trial = '0;
    bitv = '0;
    dsh = '0;
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      vm = v_r[i][63] ? -v_r[i] : v_r[i];
      if (vm >= 64'd2147483648) big = 1'b1;
    end
    vm = v_r[idx_r][63] ? -v_r[idx_r] : v_r[idx_r];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt[0] = vx;
          v_nxt[1] = vy;
          v_nxt[2] = vz;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        if (big) begin
          for (int i = 0; i < 3; i++) v_nxt[i] = v_r[i] >>> 1;
        end else begin
          ss_nxt = '0;
          idx_nxt = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        m = vm[31:0];
        sqm = 64'(m) * 64'(m);
        ss_nxt = ss_r + sqm;
        if (idx_r == 2'd2) begin
          rem_nxt = ss_r + sqm;
          root_nxt = '0;
          cnt_nxt = 6'd31;
          state_nxt = S_ROOT;
        end else idx_nxt = idx_r + 2'd1;
      end
      S_ROOT: begin
        // one result bit per cycle, top bit pair first
        bitv = 64'd1 << {cnt_r[4:0], 1'b0};
        trial = root_r + bitv;
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          root_nxt = (root_r >> 1) + bitv;
        end else root_nxt = root_r >> 1;
        if (cnt_r == 6'd0) begin
          if (ss_r == 64'd0) begin
            zero_nxt = 1'b1;
            done_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            zero_nxt = 1'b0;
            idx_nxt = '0;
            state_nxt = S_FIN;
          end
        end else cnt_nxt = cnt_r - 6'd1;
      end
      S_FIN: begin
        // load dividend |c|*16384 + len/2 for the current component
        num_nxt = {2'b00, vm[31:0], 14'd0} + 48'(root_r[32:1]);
        dr_nxt = '0;
        q_nxt = '0;
        cnt_nxt = 6'd47;
        state_nxt = S_DIV;
      end
      default: begin
        // restoring division, one quotient bit per cycle
        dsh = {dr_r[31:0], num_r[47]};
        num_nxt = num_r << 1;
        if (dsh >= root_r[32:0]) begin
          dr_nxt = dsh - root_r[32:0];
          q_nxt = (q_r >= 16'h8000) ? 16'hFFFF : {q_r[14:0], 1'b1};
        end else begin
          dr_nxt = dsh;
          q_nxt = (q_r >= 16'h8000) ? 16'hFFFF : {q_r[14:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          qc = (q_nxt > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : q_nxt;
          u_nxt[idx_r] = v_r[idx_r][63] ? -qc : qc;
          if (idx_r == 2'd2) begin
            done_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
            state_nxt = S_FIN;
          end
        end else cnt_nxt = cnt_r - 6'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      v_r[i] <= v_nxt[i];
      u_r[i] <= u_nxt[i];
    end
    ss_r <= ss_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    num_r <= num_nxt;
    dr_r <= dr_nxt;
    q_r <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign zero = zero_r;
  assign ux = u_r[0];
  assign uy = u_r[1];
  assign uz = u_r[2];

endmodule

@@ hw/rtl/fly_camera_pose_update_unit.sv @@
// Top level: pose state, command sequencer, result register.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | opcode, move_dir, speed, angles, new pose
// out_    | output    | out_valid/out_stall| position, target, front, right
// cfg_    | input     | cfg_we             | up vector component by index
//
// Move updates position, then target; rotate runs the CORDIC for pitch, then yaw,
// plus two normalizations (front, right); set pose runs two normalizations.
// The normalizer (bit-serial square root and divider) sets the item time.
// Synchronous active-low reset restores the initial pose.
// A result is held in the output register until taken; one transaction at a time.
`timescale 1ns / 1ps
module fly_camera_pose_update_unit
  import fcpu_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [1:0]         in_move_dir,
  input  logic signed [31:0] in_speed,
  input  logic signed [31:0] in_pitch_deg,
  input  logic signed [31:0] in_yaw_deg,
  input  logic signed [31:0] in_new_pos_x,
  input  logic signed [31:0] in_new_pos_y,
  input  logic signed [31:0] in_new_pos_z,
  input  logic signed [31:0] in_new_tgt_x,
  input  logic signed [31:0] in_new_tgt_y,
  input  logic signed [31:0] in_new_tgt_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_tgt_x,
  output logic signed [31:0] out_tgt_y,
  output logic signed [31:0] out_tgt_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z
);

  localparam int CW = COORD_WIDTH;
  // working width for sums: room for a 32-bit step on either side of a coordinate
  localparam int AW = ((CW > 32) ? CW : 32) + 2;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOVE  = 4'd1;
  localparam logic [3:0] S_TGT   = 4'd2;
  localparam logic [3:0] S_CP    = 4'd3;
  localparam logic [3:0] S_CY    = 4'd4;
  localparam logic [3:0] S_DIR   = 4'd5;
  localparam logic [3:0] S_NF    = 4'd6;
  localparam logic [3:0] S_CROSS = 4'd7;
  localparam logic [3:0] S_NR    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_SET   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic signed [CW-1:0] pos_r [3];
  logic signed [CW-1:0] pos_nxt [3];
  logic signed [CW-1:0] tgt_r [3];
  logic signed [CW-1:0] tgt_nxt [3];
  logic signed [15:0] frt_r [3];
  logic signed [15:0] frt_nxt [3];
  logic signed [15:0] rgt_r [3];
  logic signed [15:0] rgt_nxt [3];
  logic signed [15:0] up_r [3];
  logic [1:0] op_r, op_nxt, dir_r, dir_nxt;
  logic signed [31:0] spd_r, spd_nxt, pit_r, pit_nxt, yaw_r, yaw_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic signed [17:0] cp_r, cp_nxt, sp_r, sp_nxt;
  logic signed [63:0] vec_r [3];
  logic signed [63:0] vec_nxt [3];
  logic ostart_r, ostart_nxt, nstart_r, nstart_nxt;
  logic out_valid_r, out_valid_nxt;

  logic signed [31:0] cang;
  logic cdone, ndone, nzero;
  logic signed [17:0] ccos, csin;
  logic signed [15:0] nux, nuy, nuz;

  logic signed [15:0] dsel;
  logic signed [49:0] prod;
  logic signed [AW-1:0] stp, ssum;
  logic signed [AW-1:0] asum;
  logic signed [35:0] cprod;

  function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      if (v > AW'(CMAX)) r = CMAX;
      else if (v < AW'(CMIN)) r = CMIN;
      else r = v[CW-1:0];
      return r;
    end
  endfunction

  assign cang = (state_r == S_CP) ? pit_r : yaw_r;

  fcpu_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(ostart_r), .angle(cang),
    .done(cdone), .cos_q(ccos), .sin_q(csin)
  );

  fcpu_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(nstart_r),
    .vx(vec_r[0]), .vy(vec_r[1]), .vz(vec_r[2]),
    .done(ndone), .zero(nzero), .ux(nux), .uy(nuy), .uz(nuz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r[0] <= 16'sd0;
      up_r[1] <= UNIT_Q14;
      up_r[2] <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_X: up_r[0] <= cfg_data;
        REG_UP_Y: up_r[1] <= cfg_data;
        REG_UP_Z: up_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      tgt_nxt[i] = tgt_r[i];
      frt_nxt[i] = frt_r[i];
      rgt_nxt[i] = rgt_r[i];
      vec_nxt[i] = vec_r[i];
    end
    op_nxt = op_r;
    dir_nxt = dir_r;
    spd_nxt = spd_r;
    pit_nxt = pit_r;
    yaw_nxt = yaw_r;
    idx_nxt = idx_r;
    cp_nxt = cp_r;
    sp_nxt = sp_r;
    ostart_nxt = 1'b0;
    nstart_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    dsel = (dir_r[1]) ? rgt_r[idx_r] : frt_r[idx_r];
    prod = 50'(dsel) * 50'(spd_r);
    stp = AW'((prod + 50'sd8192) >>> 14);
    if (dir_r == DIR_BACK || dir_r == DIR_LEFT) stp = -stp;
    ssum = AW'(pos_r[idx_r]) + stp;
    asum = AW'(pos_r[idx_r]) + AW'(frt_r[idx_r] * 4);
    cprod = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_opcode;
          dir_nxt = in_move_dir;
          spd_nxt = in_speed;
          pit_nxt = (in_pitch_deg > DEG89) ? DEG89 :
                    (in_pitch_deg < -DEG89) ? -DEG89 : in_pitch_deg;
          yaw_nxt = in_yaw_deg;
          idx_nxt = '0;
          case (in_opcode)
            OP_MOVE: state_nxt = S_MOVE;
            OP_ROTATE: begin
              ostart_nxt = 1'b1;
              state_nxt = S_CP;
            end
            OP_SET: begin
              pos_nxt[0] = sat(AW'(in_new_pos_x));
              pos_nxt[1] = sat(AW'(in_new_pos_y));
              pos_nxt[2] = sat(AW'(in_new_pos_z));
              tgt_nxt[0] = sat(AW'(in_new_tgt_x));
              tgt_nxt[1] = sat(AW'(in_new_tgt_y));
              tgt_nxt[2] = sat(AW'(in_new_tgt_z));
              state_nxt = S_SET;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_MOVE: begin
        pos_nxt[idx_r] = sat(ssum);
        if (idx_r == 2'd2) begin
          idx_nxt = '0;
          state_nxt = S_TGT;
        end else idx_nxt = idx_r + 2'd1;
      end
      S_TGT: begin
        tgt_nxt[idx_r] = sat(asum);
        if (idx_r == 2'd2) begin
          idx_nxt = '0;
          if (op_r == OP_ROTATE) begin
            idx_nxt = '0;
            state_nxt = S_CROSS;
          end else state_nxt = S_OUT;
        end else idx_nxt = idx_r + 2'd1;
      end
      S_SET: begin
        for (int i = 0; i < 3; i++)
          vec_nxt[i] = 64'(tgt_r[i]) - 64'(pos_r[i]);
        nstart_nxt = 1'b1;
        state_nxt = S_NF;
      end
      S_CP: begin
        if (cdone) begin
          cp_nxt = ccos;
          sp_nxt = csin;
          ostart_nxt = 1'b1;
          state_nxt = S_CY;
        end
      end
      S_CY: begin
        if (cdone) begin
          vec_nxt[0] = 64'(36'(ccos) * 36'(cp_r));
          vec_nxt[1] = 64'(sp_r) <<< 14;
          vec_nxt[2] = 64'(36'(csin) * 36'(cp_r));
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        nstart_nxt = 1'b1;
        state_nxt = S_NF;
      end
      S_NF: begin
        if (ndone) begin
          if (!nzero) begin
            frt_nxt[0] = nux;
            frt_nxt[1] = nuy;
            frt_nxt[2] = nuz;
          end
          idx_nxt = '0;
          if (op_r == OP_ROTATE) state_nxt = S_TGT;
          else state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        // one cross-product component per cycle
        case (idx_r)
          2'd0: cprod = 36'(frt_r[1]) * 36'(up_r[2]) - 36'(frt_r[2]) * 36'(up_r[1]);
          2'd1: cprod = 36'(frt_r[2]) * 36'(up_r[0]) - 36'(frt_r[0]) * 36'(up_r[2]);
          default: cprod = 36'(frt_r[0]) * 36'(up_r[1]) - 36'(frt_r[1]) * 36'(up_r[0]);
        endcase
        vec_nxt[idx_r] = 64'(cprod);
        if (idx_r == 2'd2) begin
          nstart_nxt = 1'b1;
          state_nxt = S_NR;
        end else idx_nxt = idx_r + 2'd1;
      end
      S_NR: begin
        if (ndone) begin
          if (!nzero) begin
            rgt_nxt[0] = nux;
            rgt_nxt[1] = nuy;
            rgt_nxt[2] = nuz;
          end
          state_nxt = S_OUT;
        end
      end
      default: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      ostart_r <= 1'b0;
      nstart_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        tgt_r[i] <= '0;
        frt_r[i] <= '0;
        rgt_r[i] <= '0;
      end
      tgt_r[2] <= -(CW'(65536));
      frt_r[2] <= -UNIT_Q14;
      rgt_r[0] <= UNIT_Q14;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ostart_r <= ostart_nxt;
      nstart_r <= nstart_nxt;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
        tgt_r[i] <= tgt_nxt[i];
        frt_r[i] <= frt_nxt[i];
        rgt_r[i] <= rgt_nxt[i];
      end
    end
    for (int i = 0; i < 3; i++) vec_r[i] <= vec_nxt[i];
    op_r <= op_nxt;
    dir_r <= dir_nxt;
    spd_r <= spd_nxt;
    pit_r <= pit_nxt;
    yaw_r <= yaw_nxt;
    idx_r <= idx_nxt;
    cp_r <= cp_nxt;
    sp_r <= sp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = 32'(pos_r[0]);
  assign out_pos_y = 32'(pos_r[1]);
  assign out_pos_z = 32'(pos_r[2]);
  assign out_tgt_x = 32'(tgt_r[0]);
  assign out_tgt_y = 32'(tgt_r[1]);
  assign out_tgt_z = 32'(tgt_r[2]);
  assign out_front_x = frt_r[0];
  assign out_front_y = frt_r[1];
  assign out_front_z = frt_r[2];
  assign out_right_x = rgt_r[0];
  assign out_right_y = rgt_r[1];
  assign out_right_z = rgt_r[2];

endmodule

@@ tb/fly_camera_pose_update_unit_tb.sv @@
// Testbench: random and directed pose commands checked against a built-in pose predictor.
`timescale 1ns / 1ps
module fly_camera_pose_update_unit_tb;
  import fcpu_pkg::*;

  typedef struct {
    logic [1:0]         opcode;
    logic [1:0]         move_dir;
    logic signed [31:0] speed;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] npos[3];
    logic signed [31:0] ntgt[3];
  } cmd_t;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [31:0] tgt[3];
    logic signed [15:0] front[3];
    logic signed [15:0] right[3];
  } pose_t;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_UP_X;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = OP_MOVE;
  logic [1:0] in_move_dir = DIR_FWD;
  logic signed [31:0] in_speed = '0, in_pitch_deg = '0, in_yaw_deg = '0;
  logic signed [31:0] in_new_pos_x = '0, in_new_pos_y = '0, in_new_pos_z = '0;
  logic signed [31:0] in_new_tgt_x = '0, in_new_tgt_y = '0, in_new_tgt_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_tgt_x, out_tgt_y, out_tgt_z;
  logic signed [15:0] out_front_x, out_front_y, out_front_z;
  logic signed [15:0] out_right_x, out_right_y, out_right_z;

  fly_camera_pose_update_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  longint cam_pos[3], cam_tgt[3];
  longint cam_front[3], cam_right[3];
  longint up_vec[3];

  cmd_t  cmd_q[$];
  pose_t pose_q[$];
  int    errors = 0;
  int    n_sent = 0, n_checked = 0;
  int    op_seen[4];
  bit    tx_idle_en = 1'b1, rx_idle_en = 1'b1;
  bit    long_hold = 1'b0;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    if (a > CMAX) a = CMAX;
    if (a < CMIN) a = CMIN;
    r = a + b;
    if (r > CMAX) r = CMAX;
    if (r < CMIN) r = CMIN;
    return r;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // unit vector in Q2.14; a zero vector leaves dst alone
  task automatic to_unit(input longint src[3], inout longint dst[3]);
    longint v[3];
    longint unsigned ss;
    longint len, m, q;
    v = src;
    while (absv(v[0]) >= (64'sd1 << 31) || absv(v[1]) >= (64'sd1 << 31) ||
           absv(v[2]) >= (64'sd1 << 31)) begin
      for (int i = 0; i < 3; i++) v[i] = sra(v[i], 1);
    end
    ss = 0;
    for (int i = 0; i < 3; i++) ss += longint'(v[i] * v[i]);
    if (ss == 0) return;
    len = root64(ss);
    for (int i = 0; i < 3; i++) begin
      m = absv(v[i]);
      q = (m * 16384 + len / 2) / len;
      if (q > 16384) q = 16384;
      dst[i] = v[i] < 0 ? -q : q;
    end
  endtask

  task automatic refresh_right();
    longint c[3];
    c[0] = cam_front[1] * up_vec[2] - cam_front[2] * up_vec[1];
    c[1] = cam_front[2] * up_vec[0] - cam_front[0] * up_vec[2];
    c[2] = cam_front[0] * up_vec[1] - cam_front[1] * up_vec[0];
    to_unit(c, cam_right);
  endtask

  task automatic sin_cos(input longint ang, output longint cs, output longint sn);
    longint x, y, z, nx;
    bit neg;
    x = CORDIC_GAIN;
    y = 0;
    neg = 1'b0;
    z = ang % longint'(DEG360);
    if (z < 0) z += DEG360;
    if (z >= DEG180) z -= DEG360;
    if (z > DEG90) begin
      z -= DEG180;
      neg = 1'b1;
    end else if (z < -longint'(DEG90)) begin
      z += DEG180;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        z -= atan_deg(i[3:0]);
      end else begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        z += atan_deg(i[3:0]);
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    cs = sra(x + 32768, 16);
    sn = sra(y + 32768, 16);
  endtask

  task automatic predict_pose(input cmd_t c, output pose_t p);
    longint dv[3], stp, pit, cp, sp, cy, sy;
    case (c.opcode)
      OP_MOVE: begin
        for (int i = 0; i < 3; i++) begin
          stp = sra(((c.move_dir == DIR_FWD || c.move_dir == DIR_BACK) ?
                     cam_front[i] : cam_right[i]) * longint'(c.speed) + 8192, 14);
          if (c.move_dir == DIR_BACK || c.move_dir == DIR_LEFT) stp = -stp;
          cam_pos[i] = sat_sum(cam_pos[i], stp);
        end
        for (int i = 0; i < 3; i++) cam_tgt[i] = sat_sum(cam_pos[i], cam_front[i] * 4);
      end
      OP_ROTATE: begin
        pit = c.pitch;
        if (pit > DEG89) pit = DEG89;
        if (pit < -longint'(DEG89)) pit = -longint'(DEG89);
        sin_cos(pit, cp, sp);
        sin_cos(longint'(c.yaw), cy, sy);
        dv[0] = cy * cp;
        dv[1] = sp * 16384;
        dv[2] = sy * cp;
        to_unit(dv, cam_front);
        for (int i = 0; i < 3; i++) cam_tgt[i] = sat_sum(cam_pos[i], cam_front[i] * 4);
        refresh_right();
      end
      OP_SET: begin
        for (int i = 0; i < 3; i++) begin
          cam_pos[i] = c.npos[i];
          cam_tgt[i] = c.ntgt[i];
          dv[i] = cam_tgt[i] - cam_pos[i];
        end
        to_unit(dv, cam_front);
        refresh_right();
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = cam_pos[i][31:0];
      p.tgt[i] = cam_tgt[i][31:0];
      p.front[i] = cam_front[i][15:0];
      p.right[i] = cam_right[i][15:0];
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'(0) : 32'hffffffff;
      3: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.opcode = r < 45 ? OP_MOVE : r < 75 ? OP_ROTATE : r < 97 ? OP_SET : 2'd3;
    c.move_dir = 2'($urandom_range(0, 3));
    c.speed = $urandom_range(0, 3) == 0 ? rand_word()
              : 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    c.pitch = $urandom_range(0, 3) == 0 ? rand_word()
              : 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    c.yaw = rand_word();
    for (int i = 0; i < 3; i++) begin
      c.npos[i] = rand_word();
      c.ntgt[i] = $urandom_range(0, 9) == 0 ? c.npos[i] : rand_word();
    end
    return c;
  endfunction

  function automatic cmd_t mk(logic [1:0] op, logic [1:0] dir, logic [31:0] spd,
                              logic [31:0] pit, logic [31:0] yw);
    cmd_t c;
    c.opcode = op;
    c.move_dir = dir;
    c.speed = spd;
    c.pitch = pit;
    c.yaw = yw;
    for (int i = 0; i < 3; i++) begin
      c.npos[i] = $urandom;
      c.ntgt[i] = $urandom;
    end
    return c;
  endfunction

  // driver: offers the head of the command queue, changes at the falling edge
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) begin
        // hold payload
      end else begin
        if (tx_gap > 0) tx_gap <= tx_gap - 1;
        if (cmd_q.size() != 0 && tx_gap == 0 &&
            !(tx_idle_en && $urandom_range(0, 9) == 0)) begin
          cmd_t c;
          c = cmd_q[0];
          in_valid <= 1'b1;
          in_opcode <= c.opcode;
          in_move_dir <= c.move_dir;
          in_speed <= c.speed;
          in_pitch_deg <= c.pitch;
          in_yaw_deg <= c.yaw;
          in_new_pos_x <= c.npos[0];
          in_new_pos_y <= c.npos[1];
          in_new_pos_z <= c.npos[2];
          in_new_tgt_x <= c.ntgt[0];
          in_new_tgt_y <= c.ntgt[1];
          in_new_tgt_z <= c.ntgt[2];
        end else begin
          in_valid <= 1'b0;
          if (tx_gap == 0 && tx_idle_en && $urandom_range(0, 9) == 0)
            tx_gap <= $urandom_range(1, 15);
        end
      end
    end
  end

  // acceptance and prediction at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      cmd_t c;
      pose_t p;
      c = cmd_q.pop_front();
      predict_pose(c, p);
      pose_q.push_back(p);
      op_seen[c.opcode]++;
      n_sent++;
    end
  end

  // receiver stall
  int rx_gap = 0;
  always @(negedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
      rx_gap <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pose_t e;
      logic signed [31:0] ap[3], at[3];
      logic signed [15:0] af[3], ar[3];
      ap = '{out_pos_x, out_pos_y, out_pos_z};
      at = '{out_tgt_x, out_tgt_y, out_tgt_z};
      af = '{out_front_x, out_front_y, out_front_z};
      ar = '{out_right_x, out_right_y, out_right_z};
      if (pose_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pose_q.pop_front();
        n_checked++;
        for (int i = 0; i < 3; i++) begin
          if (ap[i] !== e.pos[i]) begin
            $error("pos[%0d] exp %0d got %0d", i, e.pos[i], ap[i]);
            errors++;
          end
          if (at[i] !== e.tgt[i]) begin
            $error("tgt[%0d] exp %0d got %0d", i, e.tgt[i], at[i]);
            errors++;
          end
          if (af[i] !== e.front[i]) begin
            $error("front[%0d] exp %0d got %0d", i, e.front[i], af[i]);
            errors++;
          end
          if (ar[i] !== e.right[i]) begin
            $error("right[%0d] exp %0d got %0d", i, e.right[i], ar[i]);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (cmd_q.size() != 0 || pose_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_up(input logic [15:0] ux, input logic [15:0] uy, input logic [15:0] uz);
    logic [15:0] vals[3];
    vals = '{ux, uy, uz};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      up_vec[i] = longint'($signed(vals[i]));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    repeat (n) cmd_q.push_back(rand_cmd());
  endtask

  initial begin
    cmd_t c;
    for (int i = 0; i < 3; i++) begin
      cam_pos[i] = 0;
      cam_tgt[i] = 0;
      cam_front[i] = 0;
      cam_right[i] = 0;
    end
    cam_tgt[2] = -65536;
    cam_front[2] = -16384;
    cam_right[0] = 16384;
    up_vec = '{0, 16384, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every direction, speed and angle extremes, clamp, wrap, zero vectors
    cmd_q.push_back(mk(OP_MOVE, DIR_FWD, 32'h00010000, 0, 0));
    cmd_q.push_back(mk(OP_MOVE, DIR_BACK, 32'h7fffffff, 0, 0));
    cmd_q.push_back(mk(OP_MOVE, DIR_RIGHT, 32'h80000000, 0, 0));
    cmd_q.push_back(mk(OP_MOVE, DIR_LEFT, 32'h7fffffff, 0, 0));
    cmd_q.push_back(mk(OP_MOVE, DIR_FWD, 0, 0, 0));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, 32'sd90 <<< 16, 0));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, -(32'sd90 <<< 16), 32'sd180 <<< 16));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, 32'h7fffffff, 32'h80000000));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, 32'h80000000, 32'h7fffffff));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, 0, -(32'sd270 <<< 16)));
    cmd_q.push_back(mk(OP_ROTATE, 0, 0, 32'sd89 <<< 16, 32'sd720 <<< 16));
    cmd_q.push_back(mk(2'd3, DIR_LEFT, 32'hffffffff, 0, 0));
    c = mk(OP_SET, 0, 0, 0, 0);
    c.npos = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
    c.ntgt = '{32'h80000000, 32'h7fffffff, 32'h80000000};
    cmd_q.push_back(c);
    c.ntgt = c.npos;  // zero-length front keeps old direction
    cmd_q.push_back(c);
    cmd_q.push_back(mk(OP_MOVE, DIR_FWD, 32'h7fffffff, 0, 0));
    c.npos = '{0, 0, 0};
    c.ntgt = '{0, 32'h00010000, 0};  // front parallel to up: right kept
    cmd_q.push_back(c);
    cmd_q.push_back(mk(OP_MOVE, DIR_RIGHT, 32'h00050000, 0, 0));
    drain();

    write_up(16'h8000, 16'h7fff, 16'h4000);
    queue_random(300);
    drain();
    write_up(16'h0000, 16'h0000, 16'h0000);
    queue_random(200);
    drain();

    // receiver held off while the sender keeps offering
    write_up(16'hc000, 16'h0000, 16'h4000);
    long_hold = 1'b1;
    queue_random(200);
    repeat (1500) @(posedge clk);
    long_hold = 1'b0;
    drain();
    write_up(16'h4000, 16'hffff, 16'h0001);
    queue_random(600);
    drain();
    write_up(16'h0000, 16'h4000, 16'h0000);
    queue_random(300);
    while (cmd_q.size() > 150) @(posedge clk);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    queue_random(300);
    drain();

    $display("pose commands accepted %0d, results checked %0d", n_sent, n_checked);
    $display("move %0d rotate %0d set %0d unused %0d, five up-vector settings",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    if (errors == 0) $display("fly_camera_pose_update_unit_tb: clean");
    else $display("fly_camera_pose_update_unit_tb: errors");
    $finish;
  end

  initial begin
    #400ms;
    $display("fly_camera_pose_update_unit_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fcpu_pkg.sv
hw/rtl/fcpu_cordic.sv
hw/rtl/fcpu_norm.sv
hw/rtl/fly_camera_pose_update_unit.sv
tb/fly_camera_pose_update_unit_tb.sv
